// File: design/polygon_area_3d_fan_defines.svh
// ----------------------------------------------------------------------------
// polygon_area_3d_fan_defines
// assertion macros shared by the polygon area block
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_3D_FAN_DEFINES_SVH
`define POLYGON_AREA_3D_FAN_DEFINES_SVH

// same-cycle implication, checking stops during reset
`define PA3F_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checking stops during reset
`define PA3F_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pa3f_pkg.sv
// ----------------------------------------------------------------------------
// pa3f_pkg
// shared constants and types of the fan-triangulated polygon area block
// ----------------------------------------------------------------------------
package pa3f_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // width and full scale of the area result
    localparam int AREA_BITS = 48;
    localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

    // status of the serial magnitude unit
    typedef struct packed {
        logic busy;
        logic done;
    } mag_status_t;

endpackage

// File: design/pa3f_channels.sv
// ----------------------------------------------------------------------------
// pa3f_channels
// valid/ready channels for vertex beats and area result beats
// ----------------------------------------------------------------------------

// one vertex per beat
interface pa3f_vertex_if import pa3f_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
    logic                         last_vertex;

    modport source
    (
        output valid, x_coord, y_coord, z_coord, last_vertex,
        input  ready
    );

    modport sink
    (
        input  valid, x_coord, y_coord, z_coord, last_vertex,
        output ready
    );
endinterface

// one element area per beat
interface pa3f_area_if import pa3f_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [AREA_BITS-1:0] twice_area;
    logic                 degenerate;
    logic                 saturated;

    modport source
    (
        output valid, twice_area, degenerate, saturated,
        input  ready
    );

    modport sink
    (
        input  valid, twice_area, degenerate, saturated,
        output ready
    );
endinterface

// File: design/pa3f_mag.sv
// ----------------------------------------------------------------------------
// pa3f_mag
// bit-serial magnitude unit: floor(sqrt(cx^2 + cy^2 + cz^2))
// squares one component after another by shift-and-add, one multiplier
// bit per cycle, then takes the root two radicand bits per cycle
// ----------------------------------------------------------------------------
`include "polygon_area_3d_fan_defines.svh"

module pa3f_mag import pa3f_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CROSS_BITS = 2 * COORD_BITS + 2,
    localparam int ROOT_BITS  = CROSS_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CROSS_BITS-1:0] cross_x,
    input  logic [CROSS_BITS-1:0] cross_y,
    input  logic [CROSS_BITS-1:0] cross_z,
    output mag_status_t           status,
    output logic [ROOT_BITS-1:0]  root
);

    localparam int MAG_BITS = CROSS_BITS - 1;
    localparam int SQ_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 1;
    localparam int CNT_BITS = $clog2(CROSS_BITS);

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_SQUARE,
        MS_ROOT
    } mag_state_t;

    mag_state_t          state_reg, state_next;
    logic                done_reg, done_next;
    logic [1:0]          comp_reg, comp_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    logic [MAG_BITS-1:0]  abs_reg[3];
    logic [MAG_BITS-1:0]  abs_next[3];
    logic [MAG_BITS-1:0]  mplier_reg, mplier_next;
    logic [SQ_BITS-1:0]   mcand_reg, mcand_next;
    logic [SQ_BITS-1:0]   sum_reg, sum_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;

    logic [CROSS_BITS-1:0]  cross_in[3];
    logic [MAG_BITS-1:0]    abs_in[3];
    logic [REM_BITS+1:0]    rem_shift;
    logic [REM_BITS+1:0]    trial;
    logic [REM_BITS+1:0]    rem_diff;

    // component magnitudes
    always_comb
    begin
        cross_in[0] = cross_x;
        cross_in[1] = cross_y;
        cross_in[2] = cross_z;
        for (int i = 0; i < 3; i++)
        begin
            if (cross_in[i][CROSS_BITS-1])
                abs_in[i] = MAG_BITS'(-cross_in[i]);
            else
                abs_in[i] = cross_in[i][MAG_BITS-1:0];
        end
    end

    // root digit trial
    always_comb
    begin
        rem_shift = {rem_reg, sum_reg[SQ_BITS-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rem_diff  = rem_shift - trial;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        comp_next   = comp_reg;
        cnt_next    = cnt_reg;
        abs_next    = abs_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        sum_next    = sum_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;

        case (state_reg)
            MS_IDLE:
            begin
                if (start)
                begin
                    abs_next    = abs_in;
                    mplier_next = abs_in[0];
                    mcand_next  = SQ_BITS'(abs_in[0]);
                    sum_next    = '0;
                    comp_next   = 2'd0;
                    cnt_next    = '0;
                    state_next  = MS_SQUARE;
                end
            end

            MS_SQUARE:
            begin
                if (mplier_reg[0])
                    sum_next = sum_reg + mcand_reg;
                mplier_next = mplier_reg >> 1;
                mcand_next  = mcand_reg << 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MAG_BITS - 1))
                begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        state_next = MS_ROOT;
                    end
                    else
                    begin
                        // next component moves to the front
                        comp_next   = comp_reg + 2'd1;
                        abs_next[0] = abs_reg[1];
                        abs_next[1] = abs_reg[2];
                        mplier_next = abs_reg[1];
                        mcand_next  = SQ_BITS'(abs_reg[1]);
                    end
                end
            end

            MS_ROOT:
            begin
                sum_next = sum_reg << 2;
                if (!rem_diff[REM_BITS+1])
                begin
                    rem_next  = rem_diff[REM_BITS-1:0];
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[REM_BITS-1:0];
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(ROOT_BITS - 1))
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = MS_IDLE;
                end
            end

            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
            comp_reg  <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        abs_reg    <= abs_next;
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
    end

    assign status.busy = (state_reg != MS_IDLE);
    assign status.done = done_reg;
    assign root        = root_reg;

    // checks
    `PA3F_CHECK(a_start_when_idle, clk, rst_n, start, state_reg == MS_IDLE, "start while busy")
    `PA3F_CHECK_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "done held over two cycles")
    `PA3F_CHECK(a_idle_after_root, clk, rst_n, $fell(status.busy), done_reg, "busy dropped without done")

endmodule

// File: design/polygon_area_3d_fan.sv
// ----------------------------------------------------------------------------
// polygon_area_3d_fan
// twice the area of one surface element by fan triangulation from its
// first vertex; cross products are formed bit-serially, their length by
// a bit-serial square and root unit, and summed with saturation
// ----------------------------------------------------------------------------
//
//   port     dir   beat
//   -------  ----  -------------------------------------------------------
//   vertex   in    x_coord, y_coord, z_coord, last_vertex: one vertex
//   result   out   twice_area, degenerate, saturated: one per element
//
// a vertex that closes a fan triangle (third and later) goes through
// COORD_BITS + 1 cross product steps, 3 * (2 * COORD_BITS + 1) squaring
// steps and 2 * COORD_BITS + 2 root steps, one bit each, with the
// launch and magnitude wait states for handoff.
// first and second vertices are taken in idle; a last vertex goes on to
// emit to load the result register, and waits there while result is stalled.
// the result register lets the next element start while a beat waits.
// reset clears all element state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "polygon_area_3d_fan_defines.svh"

module polygon_area_3d_fan import pa3f_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    pa3f_vertex_if.sink   vertex,
    pa3f_area_if.source   result
);

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int CROSS_BITS = 2 * DIFF_BITS;
    localparam int ROOT_BITS  = CROSS_BITS;
    localparam int CNT_BITS   = $clog2(DIFF_BITS);
    localparam logic [1:0] SEEN_FULL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_LAUNCH,
        ST_MAG,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [COORD_BITS-1:0] first_reg[3];
    logic [COORD_BITS-1:0] first_next[3];
    logic [COORD_BITS-1:0] prev_reg[3];
    logic [COORD_BITS-1:0] prev_next[3];
    logic [1:0]            seen_reg, seen_next;
    logic [AREA_BITS-1:0]  sum_reg, sum_next;
    logic                  sat_reg, sat_next;
    logic                  last_reg, last_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic [CROSS_BITS-1:0] mcand_a_reg[3];
    logic [CROSS_BITS-1:0] mcand_a_next[3];
    logic [CROSS_BITS-1:0] mcand_b_reg[3];
    logic [CROSS_BITS-1:0] mcand_b_next[3];
    logic [DIFF_BITS-1:0]  mplier_a_reg[3];
    logic [DIFF_BITS-1:0]  mplier_a_next[3];
    logic [DIFF_BITS-1:0]  mplier_b_reg[3];
    logic [DIFF_BITS-1:0]  mplier_b_next[3];
    logic [CROSS_BITS-1:0] acc_reg[3];
    logic [CROSS_BITS-1:0] acc_next[3];

    logic                  out_valid_reg, out_valid_next;
    logic [AREA_BITS-1:0]  out_area_reg, out_area_next;
    logic                  out_degen_reg, out_degen_next;
    logic                  out_sat_reg, out_sat_next;

    logic [COORD_BITS-1:0] cur[3];
    logic [DIFF_BITS-1:0]  u_diff[3];
    logic [DIFF_BITS-1:0]  v_diff[3];
    logic [DIFF_BITS-1:0]  op_a1[3];
    logic [DIFF_BITS-1:0]  op_b1[3];
    logic [DIFF_BITS-1:0]  op_a2[3];
    logic [DIFF_BITS-1:0]  op_b2[3];
    logic [CROSS_BITS-1:0] term_a[3];
    logic [CROSS_BITS-1:0] term_b[3];
    logic [AREA_BITS:0]    sum_wide;
    logic                  in_beat;
    logic                  out_free;
    logic                  mag_start;
    mag_status_t           mag_status;
    logic [ROOT_BITS-1:0]  mag_root;

    assign in_beat  = vertex.valid && vertex.ready;
    assign out_free = !out_valid_reg || result.ready;

    // edge vectors from the first vertex
    always_comb
    begin
        cur[0] = vertex.x_coord;
        cur[1] = vertex.y_coord;
        cur[2] = vertex.z_coord;
        for (int i = 0; i < 3; i++)
        begin
            u_diff[i] = {prev_reg[i][COORD_BITS-1], prev_reg[i]}
                      - {first_reg[i][COORD_BITS-1], first_reg[i]};
            v_diff[i] = {cur[i][COORD_BITS-1], cur[i]}
                      - {first_reg[i][COORD_BITS-1], first_reg[i]};
        end
    end

    // cross product operand routing: c = a1 * b1 - a2 * b2 per lane
    always_comb
    begin
        op_a1[0] = u_diff[1]; op_b1[0] = v_diff[2]; op_a2[0] = u_diff[2]; op_b2[0] = v_diff[1];
        op_a1[1] = u_diff[2]; op_b1[1] = v_diff[0]; op_a2[1] = u_diff[0]; op_b2[1] = v_diff[2];
        op_a1[2] = u_diff[0]; op_b1[2] = v_diff[1]; op_a2[2] = u_diff[1]; op_b2[2] = v_diff[0];
    end

    // partial products of the current multiplier bit
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            term_a[k] = mplier_a_reg[k][0] ? mcand_a_reg[k] : '0;
            term_b[k] = mplier_b_reg[k][0] ? mcand_b_reg[k] : '0;
        end
    end

    // running sum with triangle length
    assign sum_wide = {1'b0, sum_reg} + (AREA_BITS + 1)'(mag_root);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        seen_next      = seen_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        mcand_a_next   = mcand_a_reg;
        mcand_b_next   = mcand_b_reg;
        mplier_a_next  = mplier_a_reg;
        mplier_b_next  = mplier_b_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_area_next  = out_area_reg;
        out_degen_next = out_degen_reg;
        out_sat_next   = out_sat_reg;
        mag_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (seen_reg == 2'd0)
                        first_next = cur;
                    prev_next = cur;
                    seen_next = (seen_reg == SEEN_FULL) ? SEEN_FULL : seen_reg + 2'd1;
                    last_next = vertex.last_vertex;
                    if (seen_reg[1])
                    begin
                        // load the three cross product lanes
                        for (int k = 0; k < 3; k++)
                        begin
                            mcand_a_next[k]  = {{(CROSS_BITS-DIFF_BITS){op_a1[k][DIFF_BITS-1]}},
                                                op_a1[k]};
                            mcand_b_next[k]  = {{(CROSS_BITS-DIFF_BITS){op_a2[k][DIFF_BITS-1]}},
                                                op_a2[k]};
                            mplier_a_next[k] = op_b1[k];
                            mplier_b_next[k] = op_b2[k];
                            acc_next[k]      = '0;
                        end
                        cnt_next   = '0;
                        state_next = ST_CROSS;
                    end
                    else if (vertex.last_vertex)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_CROSS:
            begin
                // sign bit of the multiplier weighs negative
                for (int k = 0; k < 3; k++)
                begin
                    if (cnt_reg == CNT_BITS'(DIFF_BITS - 1))
                        acc_next[k] = acc_reg[k] - term_a[k] + term_b[k];
                    else
                        acc_next[k] = acc_reg[k] + term_a[k] - term_b[k];
                    mcand_a_next[k]  = mcand_a_reg[k] << 1;
                    mcand_b_next[k]  = mcand_b_reg[k] << 1;
                    mplier_a_next[k] = mplier_a_reg[k] >> 1;
                    mplier_b_next[k] = mplier_b_reg[k] >> 1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIFF_BITS - 1))
                    state_next = ST_LAUNCH;
            end

            ST_LAUNCH:
            begin
                mag_start  = 1'b1;
                state_next = ST_MAG;
            end

            ST_MAG:
            begin
                if (mag_status.done)
                begin
                    if (sum_wide[AREA_BITS])
                    begin
                        sum_next = AREA_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_wide[AREA_BITS-1:0];
                    end
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (seen_reg == SEEN_FULL)
                    begin
                        out_area_next  = sum_reg;
                        out_degen_next = 1'b0;
                        out_sat_next   = sat_reg;
                    end
                    else
                    begin
                        out_area_next  = '0;
                        out_degen_next = 1'b1;
                        out_sat_next   = 1'b0;
                    end
                    // element closed, start afresh
                    for (int i = 0; i < 3; i++)
                    begin
                        first_next[i] = '0;
                        prev_next[i]  = '0;
                    end
                    seen_next  = 2'd0;
                    sum_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and element registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
            seen_reg <= 2'd0;
            sum_reg  <= '0;
            sat_reg  <= 1'b0;
            last_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            seen_reg      <= seen_next;
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
        end
    end

    // cross lanes and result payload
    always_ff @(posedge clk)
    begin
        mcand_a_reg   <= mcand_a_next;
        mcand_b_reg   <= mcand_b_next;
        mplier_a_reg  <= mplier_a_next;
        mplier_b_reg  <= mplier_b_next;
        acc_reg       <= acc_next;
        out_area_reg  <= out_area_next;
        out_degen_reg <= out_degen_next;
        out_sat_reg   <= out_sat_next;
    end

    // triangle length unit
    pa3f_mag #(
        .COORD_BITS (COORD_BITS)
    ) u_mag (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mag_start),
        .cross_x (acc_reg[0]),
        .cross_y (acc_reg[1]),
        .cross_z (acc_reg[2]),
        .status  (mag_status),
        .root    (mag_root)
    );

    assign vertex.ready      = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.twice_area = out_area_reg;
    assign result.degenerate = out_degen_reg;
    assign result.saturated  = out_sat_reg;

    // checks
    `PA3F_CHECK(a_sat_full_scale, clk, rst_n, sat_reg, sum_reg == AREA_MAX, "saturated sum below full scale")
    `PA3F_CHECK(a_degen_empty, clk, rst_n, out_valid_reg && out_degen_reg, (out_area_reg == '0) && !out_sat_reg, "short element with area")
    `PA3F_CHECK(a_result_from_emit, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_EMIT, "result beat outside emit")
    `PA3F_CHECK(a_mag_done_waited, clk, rst_n, mag_status.done, state_reg == ST_MAG, "magnitude done while not waiting")

endmodule
